// ===== rtl/core/fteg_pkg.sv =====
// Shared widths, stage counts, reset values and interface types of the fog table entry generator.
// No dependencies; every other file imports this package.
package fteg_pkg;

    // Field widths
    localparam int IDX_W      = 7;
    localparam int OCT_W      = 3;
    localparam int STEP_W     = 4;
    localparam int FAR_W      = 24;
    localparam int STR_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int FOG_W      = 8;
    localparam int DENS_W     = 16;

    // Internal widths
    localparam int EXP_W      = 5;             // exponent 0..16
    localparam int MANT_W     = 8;             // mantissa 128..255
    localparam int MANT_STEPS = MANT_W - 1;    // top mantissa bit is always one
    localparam int REM_W      = STEP_W + 1;    // step divisor 16..31
    localparam int NUM_W      = 29;            // mantissa << (exponent + 5)
    localparam int NUM_SHIFT  = 5;
    localparam int DIV_STEPS  = 8;             // quotient bits per distance stage
    localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIST_W     = 25;
    localparam int PROD_W     = 33;
    localparam int FOGQ_W     = 9;             // fog quotient before saturation
    localparam int EXP_BIAS   = 8;
    localparam int MOD_STEPS  = 3;             // index < 128, table size >= 16

    // Pipeline depths
    localparam int DENS_STAGES = 3 + MANT_STEPS;
    localparam int DIST_STAGES = 1 + DIV_STAGES;
    localparam int RAMP_PRE    = 5;
    localparam int RAMP_STAGES = RAMP_PRE + FOGQ_W;

    // Constants
    localparam logic [FAR_W-1:0] FAR_MIN  = 24'd256;
    localparam logic [FAR_W-1:0] NEAR_RST = 24'd0;
    localparam logic [FAR_W-1:0] FAR_RST  = 24'd65536;
    localparam logic [STR_W-1:0] STR_RST  = 9'd256;
    localparam logic [FOG_W-1:0] FOG_MAX  = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR     = 2'd0,
        CFG_FAR      = 2'd1,
        CFG_STRENGTH = 2'd2
    } cfg_index_t;

    // Settings derived from the configuration registers
    typedef struct packed {
        logic [FAR_W-1:0] near;
        logic [FAR_W-1:0] far_c;      // far clamped to at least 1.0
        logic [FAR_W:0]   pow_l;      // 2^ceil(log2(far_c))
        logic [EXP_W-1:0] expo;
        logic [STR_W-1:0] strength;
        logic [FAR_W-1:0] span;       // ramp width, one when the ramp is flat
        logic             flat;       // far not above near
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [MANT_W-1:0] mant;
    } dens_out_t;

    typedef struct packed {
        logic [NUM_W-1:0]  quo;
        logic [OCT_W-1:0]  oct;
        logic [MANT_W-1:0] mant;
    } dist_out_t;

    typedef struct packed {
        logic [FOG_W-1:0]  fog;
        logic [MANT_W-1:0] mant;
    } ramp_out_t;

endpackage

// ===== rtl/core/fteg_dens.sv =====
// Density mantissa pipeline: index capture, table-size reduction, one mantissa bit per stage.
// Depends on fteg_pkg.
module fteg_dens
    import fteg_pkg::*;
#(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [IDX_W-1:0] in_index,
    output logic             out_valid,
    input  logic             out_ready,
    output dens_out_t        out_data
);

    localparam int N = DENS_STAGES;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [FAR_W-1:0]  rem;
        logic [MANT_W-1:0] q;
    } dens_stage_t;

    dens_stage_t      stage_reg  [N];
    dens_stage_t      stage_next [N];
    logic [N-1:0]     valid_reg;
    logic [N-1:0]     valid_next;
    logic [N:0]       stage_ready;

    function automatic logic [IDX_W-1:0] reduce_index(input logic [IDX_W-1:0] raw);
        logic [IDX_W-1:0] v;
        v = raw;
        for (int m = MOD_STEPS - 1; m >= 0; m--) begin
            if (int'(v) >= (TABLE_ENTRIES << m)) begin
                v = v - IDX_W'(TABLE_ENTRIES << m);
            end
        end
        return v;
    endfunction

    // A stage loads when it is empty or its occupant moves on
    always_comb begin
        stage_ready[N] = out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign valid_next = {valid_reg[N-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= (valid_next & stage_ready[N-1:0]) | (valid_reg & ~stage_ready[N-1:0]);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        if (k == 0) begin : g_capture
            always_comb begin
                stage_next[k]     = '0;
                stage_next[k].idx = in_index;
            end
        end else if (k == 1) begin : g_reduce
            always_comb begin
                stage_next[k]     = stage_reg[k-1];
                stage_next[k].idx = reduce_index(stage_reg[k-1].idx);
            end
        end else if (k == 2) begin : g_start
            // Top quotient bit is always one: remainder starts at 2^L - far
            always_comb begin
                stage_next[k]     = stage_reg[k-1];
                stage_next[k].rem = FAR_W'(cfg.pow_l - {1'b0, cfg.far_c});
                stage_next[k].q   = MANT_W'(1);
            end
        end else begin : g_step
            always_comb begin : step
                logic [FAR_W:0] t;
                stage_next[k] = stage_reg[k-1];
                t = {stage_reg[k-1].rem, 1'b0};
                if (t >= {1'b0, cfg.far_c}) begin
                    stage_next[k].rem = FAR_W'(t - {1'b0, cfg.far_c});
                    stage_next[k].q   = {stage_reg[k-1].q[MANT_W-2:0], 1'b1};
                end else begin
                    stage_next[k].rem = t[FAR_W-1:0];
                    stage_next[k].q   = {stage_reg[k-1].q[MANT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign in_ready      = stage_ready[0];
    assign out_valid     = valid_reg[N-1];
    assign out_data.idx  = stage_reg[N-1].idx;
    assign out_data.mant = stage_reg[N-1].q;

endmodule

// ===== rtl/core/fteg_dist.sv =====
// Entry distance divider: mantissa << (exponent + 5) over (step + 16), eight quotient bits a stage.
// Depends on fteg_pkg.
module fteg_dist
    import fteg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  dens_out_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output dist_out_t out_data
);

    localparam int N = DIST_STAGES;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [REM_W-1:0]  rem;
        logic [NUM_W-1:0]  quo;
        logic [REM_W-1:0]  b;
        logic [OCT_W-1:0]  oct;
        logic [MANT_W-1:0] mant;
    } dist_stage_t;

    dist_stage_t  stage_reg  [N];
    dist_stage_t  stage_next [N];
    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N:0]   stage_ready;

    always_comb begin
        stage_ready[N] = out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign valid_next = {valid_reg[N-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= (valid_next & stage_ready[N-1:0]) | (valid_reg & ~stage_ready[N-1:0]);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        if (k == 0) begin : g_setup
            always_comb begin : setup
                logic [EXP_W-1:0] sh;
                sh = cfg.expo + EXP_W'(NUM_SHIFT);
                stage_next[k]      = '0;
                stage_next[k].num  = NUM_W'(in_data.mant) << sh;
                stage_next[k].b    = {1'b1, in_data.idx[STEP_W-1:0]};
                stage_next[k].oct  = in_data.idx[IDX_W-1:STEP_W];
                stage_next[k].mant = in_data.mant;
            end
        end else begin : g_div
            // Shift one numerator bit into the remainder per step
            always_comb begin : div
                logic [REM_W:0] t;
                stage_next[k] = stage_reg[k-1];
                t = '0;
                for (int s = 0; s < DIV_STEPS; s++) begin
                    if ((k - 1) * DIV_STEPS + s < NUM_W) begin
                        t = {stage_next[k].rem, stage_next[k].num[NUM_W-1]};
                        stage_next[k].num = {stage_next[k].num[NUM_W-2:0], 1'b0};
                        if (t >= {1'b0, stage_next[k].b}) begin
                            t = t - {1'b0, stage_next[k].b};
                            stage_next[k].quo = {stage_next[k].quo[NUM_W-2:0], 1'b1};
                        end else begin
                            stage_next[k].quo = {stage_next[k].quo[NUM_W-2:0], 1'b0};
                        end
                        stage_next[k].rem = t[REM_W-1:0];
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign in_ready      = stage_ready[0];
    assign out_valid     = valid_reg[N-1];
    assign out_data.quo  = stage_reg[N-1].quo;
    assign out_data.oct  = stage_reg[N-1].oct;
    assign out_data.mant = stage_reg[N-1].mant;

endmodule

// ===== rtl/core/fteg_ramp.sv =====
// Fog ramp pipeline: octave shift, near/far clamp, strength multiply, nine-stage fog divider.
// Depends on fteg_pkg.
module fteg_ramp
    import fteg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  dist_out_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ramp_out_t out_data
);

    localparam int N = RAMP_STAGES;

    typedef struct packed {
        logic [DIST_W-1:0] entry_dist;
        logic              hit;
        logic [DIST_W-1:0] over;
        logic [PROD_W-1:0] prod;
        logic [FOGQ_W-1:0] q;
        logic [MANT_W-1:0] mant;
    } ramp_stage_t;

    ramp_stage_t  stage_reg  [N];
    ramp_stage_t  stage_next [N];
    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N:0]   stage_ready;

    always_comb begin
        stage_ready[N] = out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign valid_next = {valid_reg[N-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= (valid_next & stage_ready[N-1:0]) | (valid_reg & ~stage_ready[N-1:0]);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        if (k == 0) begin : g_octave
            always_comb begin
                stage_next[k]            = '0;
                stage_next[k].entry_dist = DIST_W'(in_data.quo >> in_data.oct);
                stage_next[k].mant       = in_data.mant;
            end
        end else if (k == 1) begin : g_near
            always_comb begin
                stage_next[k]      = stage_reg[k-1];
                stage_next[k].hit  = stage_reg[k-1].entry_dist > DIST_W'(cfg.near);
                stage_next[k].over = stage_reg[k-1].entry_dist - DIST_W'(cfg.near);
            end
        end else if (k == 2) begin : g_clamp
            // Flat ramp: amount one over a span of one gives full strength
            always_comb begin
                stage_next[k] = stage_reg[k-1];
                if (!stage_reg[k-1].hit) begin
                    stage_next[k].over = '0;
                end else if (cfg.flat) begin
                    stage_next[k].over = DIST_W'(1);
                end else if (stage_reg[k-1].over > DIST_W'(cfg.span)) begin
                    stage_next[k].over = DIST_W'(cfg.span);
                end
            end
        end else if (k == 3) begin : g_mult
            always_comb begin
                stage_next[k]      = stage_reg[k-1];
                stage_next[k].prod = PROD_W'(stage_reg[k-1].over[FAR_W-1:0])
                                   * PROD_W'(cfg.strength);
            end
        end else if (k == 4) begin : g_scale
            // Times 255, then drop the Q0.8 fraction of the strength
            always_comb begin : scale
                logic [PROD_W+7:0] w;
                w = {stage_reg[k-1].prod, 8'd0} - {8'd0, stage_reg[k-1].prod};
                stage_next[k]      = stage_reg[k-1];
                stage_next[k].prod = w[PROD_W+7:8];
                stage_next[k].q    = '0;
            end
        end else begin : g_div
            localparam int QB = N - 1 - k;
            always_comb begin : div
                logic [PROD_W-1:0] d;
                d = PROD_W'(cfg.span) << QB;
                stage_next[k] = stage_reg[k-1];
                if (stage_reg[k-1].prod >= d) begin
                    stage_next[k].prod  = stage_reg[k-1].prod - d;
                    stage_next[k].q[QB] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign in_ready      = stage_ready[0];
    assign out_valid     = valid_reg[N-1];
    assign out_data.fog  = stage_reg[N-1].q[FOGQ_W-1] ? FOG_MAX : stage_reg[N-1].q[FOG_W-1:0];
    assign out_data.mant = stage_reg[N-1].mant;

endmodule

// ===== rtl/core/fog_table_entry_generator_top.sv =====
// Top level of the linear fog table entry generator: configuration registers and the pipeline.
// Depends on fteg_pkg, fteg_dens, fteg_dist and fteg_ramp.
//
// Each transaction on the s_ channel carries one fog table index; each transaction on the m_
// channel returns that entry's linear fog byte and the packed density word (mantissa in bits
// 15:8, exponent in bits 7:0) in the order the indexes came in. The block is a 29-stage
// pipeline and takes one index per clock when m_ready does not stall it: 10 stages compute
// the density mantissa one quotient bit per stage, 5 stages divide the scaled mantissa by the
// entry step eight bits per stage, and 14 stages clamp the ramp, apply the strength and run
// a nine-stage restoring fog divider. Bubbles are squeezed out, so the pipeline keeps taking
// transactions while a result waits on m_ready until every stage is full. Configuration
// registers (0 near distance, 1 far distance, 2 fog strength) are written through cfg_wr_en,
// cfg_wr_index and cfg_wr_data, take effect at once and must be written only while no
// transaction is in flight; index 3 is ignored. Far distances below 1.0 act as 1.0, and the
// index is reduced modulo TABLE_ENTRIES.
module fog_table_entry_generator_top
    import fteg_pkg::*;
#(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IDX_W-1:0]      s_entry_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FOG_W-1:0]      m_fog_value,
    output logic [DENS_W-1:0]     m_density_word
);

    logic [FAR_W-1:0] near_reg;
    logic [FAR_W-1:0] far_reg;
    logic [STR_W-1:0] strength_reg;
    cfg_t             cfg_reg;
    cfg_t             cfg_next;

    logic             dens_valid;
    logic             dens_ready;
    dens_out_t        dens_data;
    logic             dist_valid;
    logic             dist_ready;
    dist_out_t        dist_data;
    ramp_out_t        ramp_data;

    // Configuration registers: write at once, ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg     <= NEAR_RST;
            far_reg      <= FAR_RST;
            strength_reg <= STR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_NEAR:     near_reg     <= cfg_wr_data[FAR_W-1:0];
                CFG_FAR:      far_reg      <= cfg_wr_data[FAR_W-1:0];
                CFG_STRENGTH: strength_reg <= cfg_wr_data[STR_W-1:0];
                default: ;
            endcase
        end
    end

    // Derived settings, registered from the configuration registers. The first
    // pipeline stage to read them is two stages past the input, so a transaction accepted
    // right after a write already sees the new values.
    always_comb begin : derive
        logic [FAR_W-1:0] far_m1;
        logic [EXP_W-1:0] lg;
        cfg_next.near     = near_reg;
        cfg_next.strength = strength_reg;
        cfg_next.far_c    = (far_reg < FAR_MIN) ? FAR_MIN : far_reg;
        // Ceiling log2: one past the top set bit of far - 1
        far_m1 = cfg_next.far_c - FAR_W'(1);
        lg     = '0;
        for (int b = 0; b < FAR_W; b++) begin
            if (far_m1[b]) begin
                lg = EXP_W'(b + 1);
            end
        end
        cfg_next.expo  = lg - EXP_W'(EXP_BIAS);
        cfg_next.pow_l = (FAR_W + 1)'(1) << lg;
        // Zero-width ramp: divide by one so the entry gets full strength past near
        cfg_next.flat  = !(cfg_next.far_c > near_reg);
        cfg_next.span  = cfg_next.flat ? FAR_W'(1) : (cfg_next.far_c - near_reg);
    end

    always_ff @(posedge aclk) begin
        cfg_reg <= cfg_next;
    end

    fteg_dens #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dens (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_index  (s_entry_index),
        .out_valid (dens_valid),
        .out_ready (dens_ready),
        .out_data  (dens_data)
    );

    fteg_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (dens_valid),
        .in_ready  (dens_ready),
        .in_data   (dens_data),
        .out_valid (dist_valid),
        .out_ready (dist_ready),
        .out_data  (dist_data)
    );

    fteg_ramp u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (dist_valid),
        .in_ready  (dist_ready),
        .in_data   (dist_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (ramp_data)
    );

    // Pack the density word: mantissa above, exponent below
    assign m_fog_value    = ramp_data.fog;
    assign m_density_word = {ramp_data.mant, (DENS_W - MANT_W)'(cfg_reg.expo)};

endmodule

// ===== rtl/core/fteg_checker.sv =====
// Port-level checker for the fog table entry generator, bound to the top level.
// Depends on fteg_pkg and fog_table_entry_generator_top.
module fteg_checker
    import fteg_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [FOG_W-1:0]      m_fog_value,
    input logic [DENS_W-1:0]     m_density_word
);

    logic [7:0] outstanding_reg;
    logic [7:0] outstanding_next;

    // Track transactions accepted but not yet returned
    always_comb begin
        outstanding_next = outstanding_reg;
        if (s_valid && s_ready) begin
            outstanding_next = outstanding_next + 8'd1;
        end
        if (m_valid && m_ready) begin
            outstanding_next = outstanding_next - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fog_value) && $stable(m_density_word))
        else $error("stalled result changed or dropped");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> outstanding_reg != 8'd0)
        else $error("result without an accepted index");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the result slot is empty");

    a_density_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_density_word[DENS_W-1] && (m_density_word[7:0] <= 8'd16))
        else $error("density word out of range");

endmodule

bind fog_table_entry_generator_top fteg_checker u_fteg_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_fog_value    (m_fog_value),
    .m_density_word (m_density_word)
);
